FILE: rtl/core/nrc_pkg.sv
// Shared types, constants and helpers for the nearest reference classifier.
// Used by nrc_lane, nrc_merge and the top module in rtl/core; depends on nothing else.
package nrc_pkg;

  // Defaults for the top-level parameters
  localparam int MAX_ENTRIES_DEF = 64;
  localparam int HU_COUNT_DEF    = 7;
  localparam int FRAC_BITS_DEF   = 24;

  // Fixed field widths
  localparam int DATA_W       = 32;
  localparam int LABEL_W      = 8;
  localparam int INDEX_W      = 6;
  localparam int DIST_W       = 48;
  localparam int MAX_FEATURES = 9;

  localparam logic [DATA_W-1:0] SIGN_BIAS = 32'h8000_0000;
  localparam logic [DIST_W-1:0] DIST_MAX  = {DIST_W{1'b1}};

  // Request action codes
  localparam logic [1:0] ACT_LOAD     = 2'd0;
  localparam logic [1:0] ACT_FINALIZE = 2'd1;
  localparam logic [1:0] ACT_CLASSIFY = 2'd2;

  typedef struct packed {
    logic [1:0]               action;
    logic [LABEL_W-1:0]       label_id;
    logic signed [DATA_W-1:0] aspect_ratio;
    logic signed [DATA_W-1:0] percent_filled;
    logic signed [DATA_W-1:0] hu_0;
    logic signed [DATA_W-1:0] hu_1;
    logic signed [DATA_W-1:0] hu_2;
    logic signed [DATA_W-1:0] hu_3;
    logic signed [DATA_W-1:0] hu_4;
    logic signed [DATA_W-1:0] hu_5;
    logic signed [DATA_W-1:0] hu_6;
  } req_t;

  typedef struct packed {
    logic               found;
    logic [LABEL_W-1:0] best_label;
    logic [INDEX_W-1:0] best_index;
    logic [DIST_W-1:0]  best_distance;
  } res_t;

  typedef logic [MAX_FEATURES-1:0][DATA_W-1:0] feat_vec_t;

  // Commands from the controller to every lane
  typedef struct packed {
    logic load;
    logic finalize;
    logic classify;
    logic metric;
  } lane_ctl_t;

  // Commands from the controller to the merge stage
  typedef struct packed {
    logic clear;
    logic start;
  } merge_ctl_t;

  // Gather the feature fields of a request in lane order
  function automatic feat_vec_t feat_of(req_t r);
    feat_vec_t v;
    v[0] = r.aspect_ratio;
    v[1] = r.percent_filled;
    v[2] = r.hu_0;
    v[3] = r.hu_1;
    v[4] = r.hu_2;
    v[5] = r.hu_3;
    v[6] = r.hu_4;
    v[7] = r.hu_5;
    v[8] = r.hu_6;
    return v;
  endfunction

endpackage

FILE: rtl/core/nrc_ram.sv
// Generic simple dual-port RAM: one write port, one read port with registered data.
// No dependencies.
module nrc_ram #(
  parameter int WIDTH = 32,
  parameter int DEPTH = 64
) (
  input  logic                                    clk,
  input  logic                                    wr_en,
  input  logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] wr_addr,
  input  logic [WIDTH-1:0]                        wr_data,
  input  logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] rd_addr,
  output logic [WIDTH-1:0]                        rd_data
);

  logic [WIDTH-1:0] mem [DEPTH];

  // Write and registered read
  always_ff @(posedge clk) begin
    if (wr_en) begin
      mem[wr_addr] <= wr_data;
    end
    rd_data <= mem[rd_addr];
  end

endmodule

FILE: rtl/core/nrc_div.sv
// Bit-serial restoring divider, one quotient bit per cycle, dividend left aligned.
// No package dependencies.
module nrc_div #(
  parameter int NW = 86,
  parameter int DW = 32
) (
  input  logic                      clk,
  input  logic                      rst,
  input  logic                      start,
  input  logic [NW-1:0]             num,
  input  logic [DW-1:0]             den,
  input  logic [$clog2(NW+1)-1:0]   steps,
  output logic                      done,
  output logic [NW-1:0]             quo,
  output logic [DW-1:0]             rem
);

  localparam int SW = $clog2(NW + 1);

  logic [SW-1:0] cnt;
  logic [DW-1:0] dvs;
  logic [DW:0]   rem_sh;
  logic [DW:0]   rem_dif;
  logic          ge;

  assign rem_sh  = {rem, quo[NW-1]};
  assign rem_dif = rem_sh - {1'b0, dvs};
  assign ge      = (rem_sh >= {1'b0, dvs});

  // Step counter and completion pulse
  always_ff @(posedge clk) begin
    if (rst) begin
      cnt  <= '0;
      done <= 1'b0;
    end else begin
      done <= 1'b0;
      if (start) begin
        cnt <= steps;
      end else if (cnt != '0) begin
        cnt <= cnt - 1'b1;
        if (cnt == SW'(1)) begin
          done <= 1'b1;
        end
      end
    end
  end

  // Shift one dividend bit into the partial remainder per cycle
  always_ff @(posedge clk) begin
    if (start) begin
      quo <= num;
      rem <= '0;
      dvs <= den;
    end else if (cnt != '0) begin
      rem <= ge ? rem_dif[DW-1:0] : rem_sh[DW-1:0];
      quo <= {quo[NW-2:0], ge};
    end
  end

endmodule

FILE: rtl/core/nrc_lane.sv
// One feature lane: feature RAM, deviation register, finalize and distance-term sequencer.
// Depends on nrc_pkg, nrc_ram and nrc_div.
module nrc_lane #(
  parameter int MAX_ENTRIES = nrc_pkg::MAX_ENTRIES_DEF,
  parameter int FRAC_BITS   = nrc_pkg::FRAC_BITS_DEF
) (
  input  logic                                              clk,
  input  logic                                              rst,
  input  nrc_pkg::lane_ctl_t                                ctl,
  input  logic [((MAX_ENTRIES > 1) ? $clog2(MAX_ENTRIES) : 1)-1:0] entry,
  input  logic [$clog2(MAX_ENTRIES+1)-1:0]                  count,
  input  logic [nrc_pkg::DATA_W-1:0]                        wr_data,
  input  logic [nrc_pkg::DATA_W-1:0]                        query,
  output logic                                              done,
  output logic [nrc_pkg::DIST_W-1:0]                        term
);

  localparam int DW   = nrc_pkg::DATA_W;
  localparam int CW   = $clog2(MAX_ENTRIES + 1);
  localparam int AW   = (MAX_ENTRIES > 1) ? $clog2(MAX_ENTRIES) : 1;
  localparam int MW   = (CW > 1) ? $clog2(CW) : 1;
  localparam int SUMW = DW + CW;
  localparam int SQW  = 2 * DW + CW;
  localparam int NW   = 2 * DW + 2 * CW;
  localparam int NNW  = 2 * CW;
  localparam int QW   = DW + FRAC_BITS;
  localparam int SW   = $clog2(NW + 1);
  localparam int DIST_W_L = nrc_pkg::DIST_W;
  localparam logic [DW-1:0] ONE_FX    = DW'(64'd1 << FRAC_BITS);
  localparam logic [DW-1:0] DEV_FLOOR = DW'((64'd1 << FRAC_BITS) / 1000);

  typedef enum logic [10:0] {
    L_IDLE  = 11'b000_0000_0001,
    L_SUM   = 11'b000_0000_0010,
    L_MEAN  = 11'b000_0000_0100,
    L_SQ    = 11'b000_0000_1000,
    L_MULN  = 11'b000_0001_0000,
    L_VSUB  = 11'b000_0010_0000,
    L_VAR   = 11'b000_0100_0000,
    L_SQRT  = 11'b000_1000_0000,
    L_CDIF  = 11'b001_0000_0000,
    L_CDIV  = 11'b010_0000_0000,
    L_CTERM = 11'b100_0000_0000
  } lane_state_t;

  lane_state_t     state;
  logic [CW-1:0]   jcnt;
  logic [2:0]      pv;
  logic [MW-1:0]   mb;
  logic [SUMW-1:0] sum;
  logic [DW-1:0]   mean;
  logic [CW-1:0]   r;
  logic [NNW-1:0]  nn;
  logic [NNW-1:0]  rr;
  logic [DW-1:0]   dreg;
  logic [63:0]     prod;
  logic [SQW-1:0]  sq_acc;
  logic [NW-1:0]   ns;
  logic [63:0]     v;
  logic [63:0]     res;
  logic [63:0]     bitv;
  logic [DW-1:0]   dev;
  logic [QW-1:0]   z;
  logic            sq_pend;

  logic [AW-1:0]   rd_addr;
  logic [DW-1:0]   rd_data;
  logic [DW-1:0]   u;
  logic [DW-1:0]   du;
  logic [DW-1:0]   qu;
  logic [DW-1:0]   diff;
  logic [64:0]     rb;
  logic            rb_ge;
  logic [63:0]     z64;
  logic [63:0]     psh;
  logic [DIST_W_L-1:0] term_next;
  logic            sum_end;
  logic            sq_end;

  logic            div_start;
  logic [NW-1:0]   div_num;
  logic [DW-1:0]   div_den;
  logic [SW-1:0]   div_steps;
  logic            div_done;
  logic [NW-1:0]   div_quo;
  logic [DW-1:0]   div_rem;

  nrc_ram #(.WIDTH(DW), .DEPTH(MAX_ENTRIES)) u_feat_ram (
    .clk     (clk),
    .wr_en   (ctl.load),
    .wr_addr (entry),
    .wr_data (wr_data),
    .rd_addr (rd_addr),
    .rd_data (rd_data)
  );

  nrc_div #(.NW(NW), .DW(DW)) u_div (
    .clk   (clk),
    .rst   (rst),
    .start (div_start),
    .num   (div_num),
    .den   (div_den),
    .steps (div_steps),
    .done  (div_done),
    .quo   (div_quo),
    .rem   (div_rem)
  );

  // Read the requested entry while idle, otherwise sweep the table
  assign rd_addr = (state == L_IDLE) ? entry : jcnt[AW-1:0];

  // Bias to unsigned order and take absolute differences
  assign u    = rd_data ^ nrc_pkg::SIGN_BIAS;
  assign du   = (u >= mean) ? (u - mean) : (mean - u);
  assign qu   = query ^ nrc_pkg::SIGN_BIAS;
  assign diff = (qu >= u) ? (qu - u) : (u - qu);
  assign rr   = NNW'(r) * NNW'(r);

  assign sum_end = (jcnt == count) && !pv[0];
  assign sq_end  = (jcnt == count) && (pv == 3'b000);

  // Integer square root step
  assign rb    = {1'b0, res} + {1'b0, bitv};
  assign rb_ge = ({1'b0, v} >= rb);

  // Distance term with saturation
  assign z64 = 64'(z);
  assign psh = prod >> FRAC_BITS;
  always_comb begin
    if (ctl.metric) begin
      term_next = (|z64[63:48]) ? nrc_pkg::DIST_MAX : z64[47:0];
    end else if (|z64[63:32] || |psh[63:48]) begin
      term_next = nrc_pkg::DIST_MAX;
    end else begin
      term_next = psh[47:0];
    end
  end

  // Divider operand selection
  always_comb begin
    div_start = 1'b0;
    div_num   = '0;
    div_den   = '0;
    div_steps = '0;
    case (state)
      L_SUM: begin
        if (sum_end) begin
          div_start = 1'b1;
          div_num   = {sum, {(NW - SUMW){1'b0}}};
          div_den   = DW'(count);
          div_steps = SW'(SUMW);
        end
      end
      L_VSUB: begin
        div_start = 1'b1;
        div_num   = ns - NW'(rr);
        div_den   = DW'(nn);
        div_steps = SW'(NW);
      end
      L_CDIF: begin
        div_start = 1'b1;
        div_num   = {diff, {(NW - DW){1'b0}}};
        div_den   = (dev == '0) ? ONE_FX : dev;
        div_steps = SW'(QW);
      end
      default: begin
      end
    endcase
  end

  // Control sequencer
  always_ff @(posedge clk) begin
    if (rst) begin
      state <= L_IDLE;
      pv    <= '0;
      done  <= 1'b0;
      dev   <= ONE_FX;
    end else begin
      done <= 1'b0;
      case (state)
        L_IDLE: begin
          if (ctl.finalize) begin
            if (count < CW'(2)) begin
              dev  <= ONE_FX;
              done <= 1'b1;
            end else begin
              pv    <= '0;
              state <= L_SUM;
            end
          end else if (ctl.classify) begin
            state <= L_CDIF;
          end
        end
        L_SUM: begin
          pv <= {pv[1:0], (jcnt < count)};
          if (sum_end) begin
            state <= L_MEAN;
          end
        end
        L_MEAN: begin
          if (div_done) begin
            pv    <= '0;
            state <= L_SQ;
          end
        end
        L_SQ: begin
          pv <= {pv[1:0], (jcnt < count)};
          if (sq_end) begin
            state <= L_MULN;
          end
        end
        L_MULN: begin
          if (mb == '0) begin
            state <= L_VSUB;
          end
        end
        L_VSUB: begin
          state <= L_VAR;
        end
        L_VAR: begin
          if (div_done) begin
            state <= L_SQRT;
          end
        end
        L_SQRT: begin
          if (bitv == '0) begin
            dev   <= (res[DW-1:0] <= DEV_FLOOR) ? ONE_FX : res[DW-1:0];
            done  <= 1'b1;
            state <= L_IDLE;
          end
        end
        L_CDIF: begin
          state <= L_CDIV;
        end
        L_CDIV: begin
          if (div_done) begin
            state <= L_CTERM;
          end
        end
        L_CTERM: begin
          if (!sq_pend) begin
            done  <= 1'b1;
            state <= L_IDLE;
          end
        end
        default: begin
          state <= L_IDLE;
        end
      endcase
    end
  end

  // Datapath registers
  always_ff @(posedge clk) begin
    case (state)
      L_IDLE: begin
        jcnt <= '0;
        sum  <= '0;
      end
      L_SUM: begin
        if (jcnt < count) begin
          jcnt <= jcnt + 1'b1;
        end
        if (pv[0]) begin
          sum <= sum + SUMW'(u);
        end
        if (sum_end) begin
          nn <= NNW'(count) * NNW'(count - 1'b1);
        end
      end
      L_MEAN: begin
        jcnt   <= '0;
        sq_acc <= '0;
        if (div_done) begin
          mean <= div_quo[DW-1:0];
          r    <= div_rem[CW-1:0];
        end
      end
      L_SQ: begin
        if (jcnt < count) begin
          jcnt <= jcnt + 1'b1;
        end
        if (pv[0]) begin
          dreg <= du;
        end
        if (pv[1]) begin
          prod <= 64'(dreg) * 64'(dreg);
        end
        if (pv[2]) begin
          sq_acc <= sq_acc + SQW'(prod);
        end
        ns <= '0;
        mb <= MW'(CW - 1);
      end
      L_MULN: begin
        ns <= (ns << 1) + (count[mb] ? NW'(sq_acc) : '0);
        if (mb != '0) begin
          mb <= mb - 1'b1;
        end
      end
      L_VAR: begin
        v    <= (|div_quo[NW-1:64]) ? '1 : div_quo[63:0];
        res  <= '0;
        bitv <= 64'd1 << 62;
      end
      L_SQRT: begin
        if (bitv != '0) begin
          v    <= rb_ge ? (v - rb[63:0]) : v;
          res  <= rb_ge ? ((res >> 1) + bitv) : (res >> 1);
          bitv <= bitv >> 2;
        end
      end
      L_CDIV: begin
        z       <= div_quo[QW-1:0];
        sq_pend <= 1'b1;
      end
      L_CTERM: begin
        if (sq_pend) begin
          prod    <= 64'(z[DW-1:0]) * 64'(z[DW-1:0]);
          sq_pend <= 1'b0;
        end else begin
          term <= term_next;
        end
      end
      default: begin
      end
    endcase
  end

endmodule

FILE: rtl/core/nrc_merge.sv
// Merge stage: saturating sum of the lane terms and running nearest-entry search.
// Depends on nrc_pkg.
module nrc_merge #(
  parameter int MAX_ENTRIES = nrc_pkg::MAX_ENTRIES_DEF,
  parameter int FEATURES    = 2 + nrc_pkg::HU_COUNT_DEF
) (
  input  logic                                              clk,
  input  logic                                              rst,
  input  nrc_pkg::merge_ctl_t                               ctl,
  input  logic [((MAX_ENTRIES > 1) ? $clog2(MAX_ENTRIES) : 1)-1:0] entry,
  input  logic [nrc_pkg::DIST_W-1:0]                        terms [FEATURES],
  output logic                                              done,
  output logic                                              found,
  output logic [((MAX_ENTRIES > 1) ? $clog2(MAX_ENTRIES) : 1)-1:0] best_index,
  output logic [nrc_pkg::DIST_W-1:0]                        best_distance
);

  localparam int AW = (MAX_ENTRIES > 1) ? $clog2(MAX_ENTRIES) : 1;
  localparam int FW = $clog2(FEATURES);
  localparam int DSW = nrc_pkg::DIST_W;

  logic            busy;
  logic            cmp;
  logic [FW-1:0]   fcnt;
  logic [DSW-1:0]  acc;
  logic [AW-1:0]   cur;
  logic [DSW:0]    sum;

  assign sum = {1'b0, acc} + {1'b0, terms[fcnt]};

  // Accumulate one lane per cycle, then compare with the best so far
  always_ff @(posedge clk) begin
    if (rst) begin
      busy  <= 1'b0;
      cmp   <= 1'b0;
      done  <= 1'b0;
      found <= 1'b0;
    end else begin
      done <= 1'b0;
      if (ctl.clear) begin
        found <= 1'b0;
      end
      if (ctl.start) begin
        busy <= 1'b1;
      end else if (busy && (fcnt == FW'(FEATURES - 1))) begin
        busy <= 1'b0;
        cmp  <= 1'b1;
      end else if (cmp) begin
        cmp  <= 1'b0;
        done <= 1'b1;
        if (!found || (acc < best_distance)) begin
          found <= 1'b1;
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (ctl.clear) begin
      best_distance <= '0;
      best_index    <= '0;
    end
    if (ctl.start) begin
      fcnt <= '0;
      acc  <= '0;
      cur  <= entry;
    end else if (busy) begin
      fcnt <= fcnt + 1'b1;
      acc  <= sum[DSW] ? nrc_pkg::DIST_MAX : sum[DSW-1:0];
    end else if (cmp && (!found || (acc < best_distance))) begin
      best_distance <= acc;
      best_index    <= cur;
    end
  end

endmodule

FILE: rtl/core/nearest_reference_classifier.sv
// Finalize and classify are paced by each lane's bit-serial divider.
// Throughput: one request at a time; a waiting result does not block the next request.
// Reset (rst, synchronous): table empty, metric 0, every deviation 1.0.
// Depends on nrc_pkg, nrc_lane, nrc_merge and nrc_ram.
module nearest_reference_classifier #(
  parameter int MAX_ENTRIES = nrc_pkg::MAX_ENTRIES_DEF,
  parameter int HU_COUNT    = nrc_pkg::HU_COUNT_DEF,
  parameter int FRAC_BITS   = nrc_pkg::FRAC_BITS_DEF
) (
  input  logic           clk,
  input  logic           rst,
  input  logic           cfg_valid,
  output logic           cfg_ready,
  input  logic           cfg_data,
  input  logic           req_valid,
  output logic           req_stall,
  input  nrc_pkg::req_t  req,
  output logic           res_valid,
  input  logic           res_stall,
  output nrc_pkg::res_t  res
);

  localparam int FEATURES = 2 + HU_COUNT;
  localparam int CW = $clog2(MAX_ENTRIES + 1);
  localparam int AW = (MAX_ENTRIES > 1) ? $clog2(MAX_ENTRIES) : 1;
  localparam int IW = nrc_pkg::INDEX_W;

  typedef enum logic [6:0] {
    ST_IDLE      = 7'b000_0001,
    ST_FIN       = 7'b000_0010,
    ST_CLS_START = 7'b000_0100,
    ST_CLS_LANE  = 7'b000_1000,
    ST_CLS_MERGE = 7'b001_0000,
    ST_CLS_LABEL = 7'b010_0000,
    ST_CLS_OUT   = 7'b100_0000
  } top_state_t;

  top_state_t          state;
  logic [CW-1:0]       count;
  logic [AW-1:0]       j;
  logic                metric;
  nrc_pkg::feat_vec_t  qreg;

  logic                accept;
  logic                res_load;
  nrc_pkg::res_t       res_next;
  nrc_pkg::feat_vec_t  feat_in;
  nrc_pkg::lane_ctl_t  lane_ctl;
  nrc_pkg::merge_ctl_t merge_ctl;
  logic [AW-1:0]       entry;
  logic [FEATURES-1:0] lane_done;
  logic [nrc_pkg::DIST_W-1:0] lane_term [FEATURES];
  logic                merge_done;
  logic                m_found;
  logic [AW-1:0]       m_index;
  logic [nrc_pkg::DIST_W-1:0]  m_dist;
  logic [nrc_pkg::LABEL_W-1:0] label_rd;

  assign cfg_ready = 1'b1;
  assign req_stall = (state != ST_IDLE);
  assign accept    = req_valid && !req_stall;
  assign feat_in   = nrc_pkg::feat_of(req);
  assign entry     = (state == ST_IDLE) ? count[AW-1:0] : j;

  // Command decode for lanes and merge stage
  always_comb begin
    lane_ctl.load     = accept && (req.action == nrc_pkg::ACT_LOAD)
                        && (count < CW'(MAX_ENTRIES));
    lane_ctl.finalize = accept && (req.action == nrc_pkg::ACT_FINALIZE);
    lane_ctl.classify = (state == ST_CLS_START);
    lane_ctl.metric   = metric;
    merge_ctl.clear   = accept && (req.action == nrc_pkg::ACT_CLASSIFY);
    merge_ctl.start   = (state == ST_CLS_LANE) && (&lane_done);
  end

  for (genvar f = 0; f < FEATURES; f++) begin : g_lane
    nrc_lane #(.MAX_ENTRIES(MAX_ENTRIES), .FRAC_BITS(FRAC_BITS)) u_lane (
      .clk     (clk),
      .rst     (rst),
      .ctl     (lane_ctl),
      .entry   (entry),
      .count   (count),
      .wr_data (feat_in[f]),
      .query   (qreg[f]),
      .done    (lane_done[f]),
      .term    (lane_term[f])
    );
  end

  nrc_merge #(.MAX_ENTRIES(MAX_ENTRIES), .FEATURES(FEATURES)) u_merge (
    .clk           (clk),
    .rst           (rst),
    .ctl           (merge_ctl),
    .entry         (j),
    .terms         (lane_term),
    .done          (merge_done),
    .found         (m_found),
    .best_index    (m_index),
    .best_distance (m_dist)
  );

  nrc_ram #(.WIDTH(nrc_pkg::LABEL_W), .DEPTH(MAX_ENTRIES)) u_label_ram (
    .clk     (clk),
    .wr_en   (lane_ctl.load),
    .wr_addr (count[AW-1:0]),
    .wr_data (req.label_id),
    .rd_addr (m_index),
    .rd_data (label_rd)
  );

  // Build the result; empty table gives all zeros
  always_comb begin
    res_next.found         = m_found;
    res_next.best_label    = m_found ? label_rd : '0;
    res_next.best_index    = m_found ? IW'(m_index) : '0;
    res_next.best_distance = m_found ? m_dist : '0;
  end
  assign res_load = (state == ST_CLS_OUT) && (!res_valid || !res_stall);

  // Request sequencer
  always_ff @(posedge clk) begin
    if (rst) begin
      state  <= ST_IDLE;
      count  <= '0;
      metric <= 1'b0;
      j      <= '0;
    end else begin
      if (cfg_valid && cfg_ready) begin
        metric <= cfg_data;
      end
      case (state)
        ST_IDLE: begin
          if (accept) begin
            case (req.action)
              nrc_pkg::ACT_LOAD: begin
                if (count < CW'(MAX_ENTRIES)) begin
                  count <= count + 1'b1;
                end
              end
              nrc_pkg::ACT_FINALIZE: begin
                state <= ST_FIN;
              end
              nrc_pkg::ACT_CLASSIFY: begin
                j     <= '0;
                state <= (count == '0) ? ST_CLS_OUT : ST_CLS_START;
              end
              default: begin
              end
            endcase
          end
        end
        ST_FIN: begin
          if (&lane_done) begin
            state <= ST_IDLE;
          end
        end
        ST_CLS_START: begin
          state <= ST_CLS_LANE;
        end
        ST_CLS_LANE: begin
          if (&lane_done) begin
            state <= ST_CLS_MERGE;
          end
        end
        ST_CLS_MERGE: begin
          if (merge_done) begin
            if (CW'(j) == count - 1'b1) begin
              state <= ST_CLS_LABEL;
            end else begin
              j     <= j + 1'b1;
              state <= ST_CLS_START;
            end
          end
        end
        ST_CLS_LABEL: begin
          state <= ST_CLS_OUT;
        end
        ST_CLS_OUT: begin
          if (res_load) begin
            state <= ST_IDLE;
          end
        end
        default: begin
          state <= ST_IDLE;
        end
      endcase
    end
  end

  // Hold the query for the whole search
  always_ff @(posedge clk) begin
    if (accept) begin
      qreg <= feat_in;
    end
  end

  // Output register
  always_ff @(posedge clk) begin
    if (rst) begin
      res_valid <= 1'b0;
    end else if (res_load) begin
      res_valid <= 1'b1;
    end else if (!res_stall) begin
      res_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (res_load) begin
      res <= res_next;
    end
  end

`ifndef ASSERT_OFF
  a_lanes_lockstep: assert property (@(posedge clk) disable iff (rst)
    (|lane_done) |-> (&lane_done))
    else $error("lanes finished out of step");
  a_count_bound: assert property (@(posedge clk) disable iff (rst)
    count <= CW'(MAX_ENTRIES))
    else $error("entry count beyond table size");
  a_entry_in_table: assert property (@(posedge clk) disable iff (rst)
    (state == ST_CLS_START) |-> (CW'(j) < count))
    else $error("search index beyond stored entries");
  a_found_matches: assert property (@(posedge clk) disable iff (rst)
    res_load |-> (res_next.found == (count != '0)))
    else $error("found flag disagrees with table contents");
`endif

endmodule

FILE: tb/tb_nearest_reference_classifier.sv
// Self-checking testbench for nearest_reference_classifier.
// Keeps its own copy of the reference table and deviations to predict every classify result.
// Depends on nrc_pkg and the RTL under rtl/core.
`timescale 1ns / 100ps

module tb_nearest_reference_classifier;

  localparam int TABLE_DEPTH = nrc_pkg::MAX_ENTRIES_DEF;
  localparam int NUM_FEAT = nrc_pkg::MAX_FEATURES;
  localparam int FRAC_Q = nrc_pkg::FRAC_BITS_DEF;
  localparam logic [1:0] ACT_UNUSED = 2'd3;
  localparam logic [31:0] ONE_Q = 32'h0100_0000;
  localparam logic [31:0] DEV_MIN = ONE_Q / 1000;
  localparam longint unsigned SAT48 = 64'h0000_FFFF_FFFF_FFFF;
  localparam int STALL_LIMIT = 30000;
  localparam int SMALL_CAP = 8;

  logic clk = 1'b0;
  logic rst = 1'b1;
  logic cfg_valid = 1'b0;
  logic cfg_ready;
  logic cfg_data = 1'b0;
  logic req_valid = 1'b0;
  logic req_stall;
  nrc_pkg::req_t req = '0;
  logic res_valid;
  logic res_stall = 1'b0;
  nrc_pkg::res_t res;

  nearest_reference_classifier dut (
    .clk(clk), .rst(rst),
    .cfg_valid(cfg_valid), .cfg_ready(cfg_ready), .cfg_data(cfg_data),
    .req_valid(req_valid), .req_stall(req_stall), .req(req),
    .res_valid(res_valid), .res_stall(res_stall), .res(res)
  );

  always begin
    #6 clk = 1'b1;
    #6 clk = 1'b0;
  end

  // Shadow state of the classifier
  logic [7:0]  shadow_label [TABLE_DEPTH];
  logic [31:0] shadow_feat [TABLE_DEPTH][NUM_FEAT];
  int unsigned shadow_count = 0;
  logic [31:0] shadow_dev [NUM_FEAT];
  logic        shadow_metric = 1'b0;

  nrc_pkg::req_t pending_reqs[$];
  nrc_pkg::res_t expected_matches[$];
  int   mismatches = 0;
  int   accepted_reqs = 0;
  int   checked_matches = 0;
  int   found_none = 0;
  int   idle_cycles = 0;
  bit   req_taken = 1'b0;
  int   send_gap = 0;
  int   send_gap_max = 1;
  int   recv_hold = 0;
  int   long_hold = 0;
  bit   recv_quiet = 1'b0;
  int   gen_count = 0;

  // Append one request to the send queue
  function automatic void enqueue_req(nrc_pkg::req_t r);
    pending_reqs.insert(pending_reqs.size(), r);
  endfunction

  function automatic logic [31:0] feat_at(nrc_pkg::req_t r, int f);
    case (f)
      0: return r.aspect_ratio;
      1: return r.percent_filled;
      2: return r.hu_0;
      3: return r.hu_1;
      4: return r.hu_2;
      5: return r.hu_3;
      6: return r.hu_4;
      7: return r.hu_5;
      default: return r.hu_6;
    endcase
  endfunction

  function automatic longint unsigned root_floor(longint unsigned v);
    longint unsigned acc_root;
    longint unsigned probe;
    acc_root = 0;
    probe = 64'h4000_0000_0000_0000;
    while (probe > v) probe >>= 2;
    while (probe != 0) begin
      if (v >= acc_root + probe) begin
        v -= acc_root + probe;
        acc_root = (acc_root >> 1) + probe;
      end else begin
        acc_root >>= 1;
      end
      probe >>= 2;
    end
    return acc_root;
  endfunction

  // Sample deviation of one feature column over the shadow table
  function automatic logic [31:0] column_deviation(int f);
    longint unsigned total, avg, rem, u, d, var_q, sd;
    logic [127:0] sq_sum;
    int unsigned n;
    n = shadow_count;
    total = 0;
    sq_sum = '0;
    if (n < 2) return ONE_Q;
    for (int j = 0; j < n; j++) total += {32'd0, shadow_feat[j][f] ^ nrc_pkg::SIGN_BIAS};
    avg = total / n;
    rem = total - avg * n;
    for (int j = 0; j < n; j++) begin
      u = {32'd0, shadow_feat[j][f] ^ nrc_pkg::SIGN_BIAS};
      d = (u >= avg) ? u - avg : avg - u;
      sq_sum += {64'd0, d * d};
    end
    sq_sum = sq_sum * 128'(n);
    sq_sum = sq_sum - 128'(32'(rem * rem));
    sq_sum = sq_sum / 128'(n * (n - 1));
    var_q = (sq_sum[127:64] != 0) ? 64'hFFFF_FFFF_FFFF_FFFF : sq_sum[63:0];
    sd = root_floor(var_q);
    if (sd > 64'hFFFF_FFFF) sd = 64'hFFFF_FFFF;
    if (sd <= 64'(DEV_MIN)) return ONE_Q;
    return sd[31:0];
  endfunction

  // Scaled distance from a query to one shadow entry
  function automatic longint unsigned scaled_distance(int j, nrc_pkg::req_t q);
    longint unsigned a, b, diff, sd, z, term, total;
    total = 0;
    for (int f = 0; f < NUM_FEAT; f++) begin
      a = {32'd0, feat_at(q, f) ^ nrc_pkg::SIGN_BIAS};
      b = {32'd0, shadow_feat[j][f] ^ nrc_pkg::SIGN_BIAS};
      diff = (a >= b) ? a - b : b - a;
      sd = (shadow_dev[f] != 0) ? 64'(shadow_dev[f]) : 64'(ONE_Q);
      z = (diff << FRAC_Q) / sd;
      if (shadow_metric == 1'b0)
        term = (z > 64'hFFFF_FFFF) ? SAT48 : (z * z) >> FRAC_Q;
      else term = z;
      if (term > SAT48) term = SAT48;
      total += term;
      if (total > SAT48) total = SAT48;
    end
    return total;
  endfunction

  // Apply one accepted request to the shadow state
  function automatic void apply_request(nrc_pkg::req_t r);
    logic [31:0] new_dev [NUM_FEAT];
    nrc_pkg::res_t m;
    longint unsigned d, best;
    bit hit;
    case (r.action)
      nrc_pkg::ACT_LOAD: begin
        if (shadow_count < TABLE_DEPTH) begin
          shadow_label[shadow_count] = r.label_id;
          for (int f = 0; f < NUM_FEAT; f++) shadow_feat[shadow_count][f] = feat_at(r, f);
          shadow_count++;
        end
      end
      nrc_pkg::ACT_FINALIZE: begin
        for (int f = 0; f < NUM_FEAT; f++) new_dev[f] = column_deviation(f);
        shadow_dev = new_dev;
      end
      nrc_pkg::ACT_CLASSIFY: begin
        m = '0;
        hit = 1'b0;
        best = 0;
        for (int j = 0; j < shadow_count; j++) begin
          d = scaled_distance(j, r);
          if (!hit || d < best) begin
            hit = 1'b1;
            best = d;
            m.best_label = shadow_label[j];
            m.best_index = j[5:0];
          end
        end
        m.found = hit;
        m.best_distance = best[47:0];
        expected_matches.insert(expected_matches.size(), m);
      end
      default: ;
    endcase
  endfunction

  function automatic nrc_pkg::req_t make_req(logic [1:0] act, logic [7:0] lab, logic [31:0] v);
    nrc_pkg::req_t r;
    r = {act, lab, {NUM_FEAT{v}}};
    return r;
  endfunction

  function automatic logic [31:0] rand_feature();
    int pick;
    pick = $urandom_range(0, 15);
    if (pick == 0) return 32'h7FFF_FFFF;
    if (pick == 1) return 32'h8000_0000;
    if (pick < 4) return $urandom;
    return $urandom_range(0, 32'h0400_0000) - 32'h0200_0000;
  endfunction

  // Random request: loads only while the table is below the cap
  function automatic nrc_pkg::req_t rand_request(int cap);
    nrc_pkg::req_t r;
    int pick;
    logic [31:0] v [NUM_FEAT];
    for (int f = 0; f < NUM_FEAT; f++) v[f] = rand_feature();
    r = '0;
    r.label_id = 8'($urandom);
    r.aspect_ratio = v[0]; r.percent_filled = v[1];
    r.hu_0 = v[2]; r.hu_1 = v[3]; r.hu_2 = v[4]; r.hu_3 = v[5];
    r.hu_4 = v[6]; r.hu_5 = v[7]; r.hu_6 = v[8];
    pick = $urandom_range(0, 99);
    if (pick < 25 && gen_count < cap) r.action = nrc_pkg::ACT_LOAD;
    else if (pick < 35) r.action = nrc_pkg::ACT_FINALIZE;
    else if (pick < 38) r.action = ACT_UNUSED;
    else r.action = nrc_pkg::ACT_CLASSIFY;
    if (r.action == nrc_pkg::ACT_LOAD) gen_count++;
    return r;
  endfunction

  // Send side: hold a stalled transfer, otherwise present the next item after a gap
  always @(negedge clk) begin
    if (!rst && (!req_valid || req_taken)) begin
      req_taken = 1'b0;
      if (send_gap > 0) begin
        send_gap--;
        req_valid <= 1'b0;
      end else if (pending_reqs.size() != 0) begin
        req <= pending_reqs[0];
        req_valid <= 1'b1;
        if (send_gap_max == 0) send_gap = 0;
        else if ($urandom_range(0, 9) == 0) send_gap = $urandom_range(8, 40);
        else send_gap = $urandom_range(0, send_gap_max);
      end else begin
        req_valid <= 1'b0;
      end
    end
  end

  // Receive side: random stalls plus the long hold-off
  always @(negedge clk) begin
    if (long_hold > 0) begin
      long_hold--;
      res_stall <= 1'b1;
    end else if (recv_hold > 0) begin
      recv_hold--;
      res_stall <= 1'b1;
    end else if (recv_quiet || $urandom_range(0, 9) < 7) begin
      res_stall <= 1'b0;
    end else begin
      recv_hold = ($urandom_range(0, 9) == 0) ? $urandom_range(10, 60) : $urandom_range(0, 3);
      res_stall <= 1'b1;
    end
  end

  // Accept requests, check results, watch for a hang
  always @(posedge clk) begin
    if (!rst) begin
      if (req_valid && !req_stall && !req_taken) begin
        apply_request(req);
        void'(pending_reqs.pop_front());
        req_taken = 1'b1;
        accepted_reqs++;
        idle_cycles = 0;
      end else if (!(res_valid && !res_stall)) begin
        idle_cycles++;
      end
      if (res_valid && !res_stall) begin
        idle_cycles = 0;
        if (expected_matches.size() == 0) begin
          mismatches++;
          if (mismatches <= 10) $display("unexpected result transfer: %p", res);
        end else begin
          if (res !== expected_matches[0]) begin
            mismatches++;
            if (mismatches <= 10) begin
              $display("mismatch: expected found=%0d label=%0d index=%0d dist=%0h",
                       expected_matches[0].found, expected_matches[0].best_label,
                       expected_matches[0].best_index, expected_matches[0].best_distance);
              $display("          got      found=%0d label=%0d index=%0d dist=%0h",
                       res.found, res.best_label, res.best_index, res.best_distance);
            end
          end
          if (!expected_matches[0].found) found_none++;
          void'(expected_matches.pop_front());
          checked_matches++;
        end
      end
      if (idle_cycles >= STALL_LIMIT) begin
        $display("timeout: no transfer for %0d cycles", STALL_LIMIT);
        $display("tb_nearest_reference_classifier NOT OK");
        $finish;
      end
    end
  end

  task automatic drain();
    while (pending_reqs.size() != 0 || expected_matches.size() != 0) @(posedge clk);
    // a trailing finalize or load produces no result, so let it finish
    repeat (400) @(posedge clk);
  endtask

  task automatic write_metric(logic m);
    @(negedge clk);
    cfg_valid <= 1'b1;
    cfg_data <= m;
    do @(posedge clk); while (!cfg_ready);
    shadow_metric = m;
    @(negedge clk);
    cfg_valid <= 1'b0;
  endtask

  task automatic random_phase(logic m, int count, int cap);
    write_metric(m);
    for (int i = 0; i < count; i++) enqueue_req(rand_request(cap));
    drain();
  endtask

  initial begin
    nrc_pkg::req_t fill_req;
    for (int f = 0; f < NUM_FEAT; f++) shadow_dev[f] = ONE_Q;
    repeat (7) @(posedge clk);
    @(negedge clk);
    rst <= 1'b0;

    // Directed: empty table, single entry, zero and small deviation, saturation ties, extremes
    enqueue_req(make_req(nrc_pkg::ACT_CLASSIFY, 8'd0, 32'h0));
    enqueue_req(make_req(nrc_pkg::ACT_FINALIZE, 8'd0, 32'h0));
    enqueue_req(make_req(ACT_UNUSED, 8'hFF, 32'hFFFF_FFFF));
    enqueue_req(make_req(nrc_pkg::ACT_LOAD, 8'd255, 32'h0));
    enqueue_req(make_req(nrc_pkg::ACT_FINALIZE, 8'd0, 32'h0));
    enqueue_req(make_req(nrc_pkg::ACT_CLASSIFY, 8'd0, 32'h8000_0000));
    enqueue_req(make_req(nrc_pkg::ACT_LOAD, 8'd0, 32'h0));
    enqueue_req(make_req(nrc_pkg::ACT_FINALIZE, 8'd0, 32'h0));
    enqueue_req(make_req(nrc_pkg::ACT_CLASSIFY, 8'd0, 32'h0));
    enqueue_req(make_req(nrc_pkg::ACT_LOAD, 8'hAA, 32'd40000));
    enqueue_req(make_req(nrc_pkg::ACT_FINALIZE, 8'd0, 32'h0));
    enqueue_req(make_req(nrc_pkg::ACT_CLASSIFY, 8'd0, 32'h7FFF_FFFF));
    enqueue_req(make_req(nrc_pkg::ACT_CLASSIFY, 8'd0, 32'h8000_0000));
    enqueue_req(make_req(nrc_pkg::ACT_CLASSIFY, 8'd0, 32'd20000));
    enqueue_req(make_req(nrc_pkg::ACT_LOAD, 8'h55, 32'h7FFF_FFFF));
    enqueue_req(make_req(nrc_pkg::ACT_LOAD, 8'd1, 32'h8000_0000));
    enqueue_req(make_req(nrc_pkg::ACT_CLASSIFY, 8'd0, 32'h7FFF_FFFF));
    enqueue_req(make_req(nrc_pkg::ACT_FINALIZE, 8'd0, 32'h0));
    enqueue_req(make_req(nrc_pkg::ACT_CLASSIFY, 8'd0, 32'h8000_0000));
    enqueue_req(make_req(nrc_pkg::ACT_CLASSIFY, 8'd0, 32'hFFFF_FFFF));
    gen_count = 5;
    drain();
    write_metric(1'b1);
    enqueue_req(make_req(nrc_pkg::ACT_CLASSIFY, 8'd0, 32'h7FFF_FFFF));
    enqueue_req(make_req(nrc_pkg::ACT_CLASSIFY, 8'd0, 32'd20000));
    drain();

    // Random phases on a small table, one with a long receiver hold-off
    random_phase(1'b1, 300, SMALL_CAP);
    long_hold = 6000;
    random_phase(1'b0, 300, SMALL_CAP);
    send_gap_max = 0;
    recv_quiet = 1'b1;
    random_phase(1'b1, 250, SMALL_CAP);
    send_gap_max = 3;
    recv_quiet = 1'b0;
    random_phase(1'b0, 300, SMALL_CAP);

    // Fill the table, then classify against the full table in both metrics
    write_metric(1'b1);
    while (gen_count < TABLE_DEPTH + 4) begin
      fill_req = make_req(nrc_pkg::ACT_LOAD, 8'($urandom), rand_feature());
      fill_req.hu_3 = $urandom;
      enqueue_req(fill_req);
      gen_count++;
    end
    enqueue_req(make_req(nrc_pkg::ACT_FINALIZE, 8'd0, 32'h0));
    for (int i = 0; i < 12; i++) enqueue_req(rand_request(0));
    drain();
    random_phase(1'b0, 12, 0);

    $display("covered %0d accepted requests, %0d classify results checked (%0d on an empty table)",
             accepted_reqs, checked_matches, found_none);
    $display("both metrics, table sizes up to %0d entries, %0d mismatches",
             shadow_count, mismatches);
    if (mismatches == 0) begin
      $display("tb_nearest_reference_classifier OK");
    end else begin
      $display("tb_nearest_reference_classifier NOT OK");
    end
    $finish;
  end

endmodule
